// ===== hw/rtl/nhp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhp_pkg
// shared types, constants and header decode functions for the header parser
// ----------------------------------------------------------------------------
package nhp_pkg;

    // header byte check
    localparam logic [7:0] HDR_MASK  = 8'hc8;
    localparam logic [7:0] HDR_MATCH = 8'h80;

    // address kind bytes
    localparam logic [7:0] KIND_LOCAL = 8'h80;
    localparam logic [7:0] KIND_XNET  = 8'ha0;
    localparam logic [7:0] KIND_MCAST = 8'hf0;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    // byte positions within a frame
    localparam logic [3:0] POS_SRC_MAC = 4'd0;
    localparam logic [3:0] POS_DST_MAC = 4'd1;
    localparam logic [3:0] POS_LEN     = 4'd2;
    localparam logic [3:0] POS_HDR     = 4'd3;
    localparam logic [3:0] POS_FIELD0  = 4'd4;

    // slots of collected header fields
    localparam logic [2:0] SL_SRC_NET   = 3'd0;
    localparam logic [2:0] SL_DST_NET   = 3'd2;
    localparam logic [2:0] SL_SPORT_LO  = 3'd4;
    localparam logic [2:0] SL_SPORT_HI  = 3'd5;
    localparam logic [2:0] SL_DPORT_LO  = 3'd6;
    localparam logic [2:0] SL_DPORT_HI  = 3'd7;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  src_kind;
        logic [7:0]  src_net;
        logic [7:0]  src_node;
        logic [7:0]  dst_kind;
        logic [7:0]  dst_net;
        logic [7:0]  dst_node;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  bus_src_mac;
        logic [7:0]  payload_len;
        logic [3:0]  payload_offset;
        logic [1:0]  status;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

    // header length in bytes, 3 to 9
    function automatic logic [3:0] hdr_len(input logic [7:0] h);
        logic [3:0] n;
        n = 4'd3;
        if (h[4]) n = n + 4'd2;
        if (h[5] | h[4]) n = n + 4'd2;
        if (h[1]) n = n + 4'd1;
        if (h[0]) n = n + 4'd1;
        return n;
    endfunction

    // field slot for header byte k, k counted from 1
    function automatic logic [2:0] slot_for(input logic [7:0] h, input logic [3:0] k);
        logic [3:0] r;
        logic [3:0] na;
        logic [3:0] nb;
        logic [2:0] s;
        r  = k - 4'd1;
        na = h[4] ? 4'd2 : 4'd0;
        nb = (h[5] | h[4]) ? 4'd2 : 4'd0;
        s  = SL_DPORT_HI;
        if (r < na) begin
            s = r[2:0];
        end else begin
            r = r - na;
            if (r < nb) begin
                s = SL_DST_NET + r[2:0];
            end else begin
                r = r - nb;
                if (r == 4'd0) begin
                    s = SL_SPORT_LO;
                end else begin
                    r = r - 4'd1;
                    if (h[1] && r == 4'd0) begin
                        s = SL_SPORT_HI;
                    end else begin
                        if (h[1]) r = r - 4'd1;
                        s = (r == 4'd0) ? SL_DPORT_LO : SL_DPORT_HI;
                    end
                end
            end
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/nhp_parse.sv =====
// ----------------------------------------------------------------------------
// nhp_parse
// frame position tracking, header field capture and result decode
// ----------------------------------------------------------------------------
module nhp_parse import nhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_word   i_word,
    input  logic [7:0] i_local_net,
    output t_result    o_res
);

    logic [3:0] r_pos,    n_pos;
    logic       r_active, n_active;
    logic [7:0] r_hdr,    n_hdr;
    logic [7:0] r_src,    n_src;
    logic [7:0] r_dst,    n_dst;
    logic [7:0] r_len,    n_len;
    logic [3:0] r_total,  n_total;
    logic [7:0] r_fc [8];
    logic [7:0] n_fc [8];

    logic [3:0] w_pos;
    logic       w_active;
    logic [3:0] w_k;
    logic [7:0] w_b;
    t_result    w_res;

    assign w_b = i_word.frame_byte;

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        n_hdr    = r_hdr;
        n_src    = r_src;
        n_dst    = r_dst;
        n_len    = r_len;
        n_total  = r_total;
        n_fc     = r_fc;
        w_res    = '0;
        w_pos    = r_pos;
        w_active = r_active;
        if (i_step) begin
            // a start byte always restarts the frame
            if (i_word.frame_start) begin
                w_pos    = POS_SRC_MAC;
                w_active = 1'b1;
                n_fc     = '{default: 8'h00};
            end
        end
        w_k = w_pos - POS_HDR;
        if (i_step) begin
            n_pos    = w_pos;
            n_active = w_active;
            if (w_active) begin
                unique case (w_pos)
                    POS_SRC_MAC: begin
                        n_src = w_b;
                        n_pos = POS_DST_MAC;
                    end
                    POS_DST_MAC: begin
                        n_dst = w_b;
                        n_pos = POS_LEN;
                    end
                    POS_LEN: begin
                        n_len = w_b;
                        n_pos = POS_HDR;
                    end
                    POS_HDR: begin
                        n_hdr = w_b;
                        if ((w_b & HDR_MASK) != HDR_MATCH) begin
                            n_active                = 1'b0;
                            w_res.valid             = 1'b1;
                            w_res.word.bus_src_mac  = r_src;
                            w_res.word.status       = ST_BAD_HDR;
                        end else begin
                            n_total = hdr_len(w_b);
                            n_pos   = POS_FIELD0;
                        end
                    end
                    default: begin
                        n_fc[slot_for(r_hdr, w_k)] = w_b;
                        if ((w_k + 4'd1) < r_total) begin
                            n_pos = w_pos + 4'd1;
                        end else begin
                            n_active    = 1'b0;
                            w_res.valid = 1'b1;
                            if (r_hdr[4]) begin
                                w_res.word.src_kind = KIND_XNET;
                                w_res.word.src_net  = n_fc[SL_SRC_NET];
                                w_res.word.src_node = n_fc[SL_SRC_NET + 3'd1];
                            end else begin
                                w_res.word.src_kind = KIND_LOCAL;
                                w_res.word.src_net  = i_local_net;
                                w_res.word.src_node = r_src;
                            end
                            if (r_hdr[5] | r_hdr[4]) begin
                                w_res.word.dst_kind = r_hdr[5] ? KIND_MCAST : KIND_XNET;
                                w_res.word.dst_net  = n_fc[SL_DST_NET];
                                w_res.word.dst_node = n_fc[SL_DST_NET + 3'd1];
                            end else begin
                                w_res.word.dst_kind = KIND_LOCAL;
                                w_res.word.dst_net  = i_local_net;
                                w_res.word.dst_node = r_dst;
                            end
                            w_res.word.src_port = {r_hdr[1] ? n_fc[SL_SPORT_HI] : 8'h00,
                                                   n_fc[SL_SPORT_LO]};
                            w_res.word.dst_port = {r_hdr[0] ? n_fc[SL_DPORT_HI] : 8'h00,
                                                   n_fc[SL_DPORT_LO]};
                            w_res.word.bus_src_mac    = r_src;
                            w_res.word.payload_offset = POS_HDR + r_total;
                            if (r_len < {4'h0, r_total}) begin
                                w_res.word.payload_len = 8'h00;
                                w_res.word.status      = ST_SHORT;
                            end else begin
                                w_res.word.payload_len = r_len - {4'h0, r_total};
                                w_res.word.status      = ST_OK;
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_SRC_MAC;
            r_active <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_len   <= n_len;
        r_total <= n_total;
        r_fc    <= n_fc;
    end

endmodule

// ===== hw/rtl/net_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// net_header_parser_top
// decodes the bus and network header of received frames, one byte a word
// ----------------------------------------------------------------------------
// result: the byte that ends the header (or the bad header byte) is decoded
//   combinationally from the input register as it steps the parser, and the
//   result word is captured in the output register
// throughput: one frame byte per cycle while no held result stalls the input,
//   set by the single-pass decode between the input and result registers
// reset: synchronous active low; parser idles until a start byte, local_net = 0
// ----------------------------------------------------------------------------
module net_header_parser_top import nhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // frame byte input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    // decoded header output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word,
    // local_net register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;

    // result register
    logic      r_out_valid;
    t_out_word r_out_word;

    // configuration
    logic [7:0] r_local_net;

    logic      w_adv;      // input word moves into the parser this cycle
    t_result   w_res;

    // the parser may step whenever the result register is empty or drains
    // this cycle; otherwise the word waits in the input register
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_net <= 8'h00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_net <= i_cfg_data;
        end
    end

    // input register, refilled whenever it is not held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    nhp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_word      (r_in_word),
        .i_local_net (r_local_net),
        .o_res       (w_res)
    );

    // result register: loaded on each parser step (most steps carry no
    // result), otherwise emptied once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_word <= w_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a parser result always lands in the result register
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.valid) |=> r_out_valid)
        else $error("parser result lost");

    // a bad header result carries no length or offset
    a_bad_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_BAD_HDR) |->
        (o_out_word.payload_len == 8'h00 && o_out_word.payload_offset == 4'h0))
        else $error("bad header result with nonzero length fields");

    // a decoded header places the payload between bytes 6 and 12
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_BAD_HDR) |->
        (o_out_word.payload_offset >= 4'd6 && o_out_word.payload_offset <= 4'd12))
        else $error("payload offset out of range");

endmodule

// ===== sim/nhp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhp_result_checker
// follows every accepted frame byte with its own header decoder, queues the
// header word each frame should give and compares the words that leave the
// parser against it, field by field
// ----------------------------------------------------------------------------
module nhp_result_checker import nhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_checked,
    output int         o_mismatches
);

    // decoder state
    logic [7:0] local_net;
    logic [3:0] byte_pos;
    logic       in_frame;
    logic [7:0] hdr_byte;
    logic [7:0] src_mac;
    logic [7:0] dst_mac;
    logic [7:0] frame_len;
    logic [3:0] hdr_bytes;
    logic [7:0] field_bytes [8];
    logic [2:0] slot_order [$];

    t_out_word  expected_hdrs [$];
    t_out_word  want;
    int         n_mismatch = 0;
    int         n_checked = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        n_mismatch++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h want %h (result %0d)",
                                      name, got, exp_val, n_checked));
    endtask

    task automatic decode_byte(input t_in_word w);
        t_out_word  r;
        logic [7:0] b;
        int         idx;
        b = w.frame_byte;
        r = '0;
        if (w.frame_start) begin
            byte_pos    = POS_SRC_MAC;
            in_frame    = 1'b1;
            field_bytes = '{default: 8'h00};
        end
        if (!in_frame) return;

        case (byte_pos)
            POS_SRC_MAC: src_mac   = b;
            POS_DST_MAC: dst_mac   = b;
            POS_LEN:     frame_len = b;
            POS_HDR: begin
                hdr_byte = b;
                if ((b & HDR_MASK) != HDR_MATCH) begin
                    in_frame      = 1'b0;
                    r.bus_src_mac = src_mac;
                    r.status      = ST_BAD_HDR;
                    expected_hdrs.push_back(r);
                    return;
                end
                // order in which the field bytes follow the header byte
                slot_order.delete();
                if (b[4]) begin
                    slot_order.push_back(SL_SRC_NET);
                    slot_order.push_back(SL_SRC_NET + 3'd1);
                end
                if (b[5] | b[4]) begin
                    slot_order.push_back(SL_DST_NET);
                    slot_order.push_back(SL_DST_NET + 3'd1);
                end
                slot_order.push_back(SL_SPORT_LO);
                if (b[1]) slot_order.push_back(SL_SPORT_HI);
                slot_order.push_back(SL_DPORT_LO);
                if (b[0]) slot_order.push_back(SL_DPORT_HI);
                hdr_bytes = 4'(1 + slot_order.size());
            end
            default: begin
                idx = int'(byte_pos) - int'(POS_FIELD0);
                field_bytes[slot_order[idx]] = b;
                if (idx + 2 >= int'(hdr_bytes)) begin
                    in_frame = 1'b0;
                    if (hdr_byte[4]) begin
                        r.src_kind = KIND_XNET;
                        r.src_net  = field_bytes[SL_SRC_NET];
                        r.src_node = field_bytes[SL_SRC_NET + 3'd1];
                    end else begin
                        r.src_kind = KIND_LOCAL;
                        r.src_net  = local_net;
                        r.src_node = src_mac;
                    end
                    if (hdr_byte[5:4] != 2'b00) begin
                        r.dst_kind = hdr_byte[5] ? KIND_MCAST : KIND_XNET;
                        r.dst_net  = field_bytes[SL_DST_NET];
                        r.dst_node = field_bytes[SL_DST_NET + 3'd1];
                    end else begin
                        r.dst_kind = KIND_LOCAL;
                        r.dst_net  = local_net;
                        r.dst_node = dst_mac;
                    end
                    r.src_port = {hdr_byte[1] ? field_bytes[SL_SPORT_HI] : 8'h00,
                                  field_bytes[SL_SPORT_LO]};
                    r.dst_port = {hdr_byte[0] ? field_bytes[SL_DPORT_HI] : 8'h00,
                                  field_bytes[SL_DPORT_LO]};
                    r.bus_src_mac    = src_mac;
                    r.payload_offset = 4'(3 + hdr_bytes);
                    if (frame_len < 8'(hdr_bytes)) begin
                        r.payload_len = 8'h00;
                        r.status      = ST_SHORT;
                    end else begin
                        r.payload_len = frame_len - 8'(hdr_bytes);
                        r.status      = ST_OK;
                    end
                    expected_hdrs.push_back(r);
                    return;
                end
            end
        endcase
        byte_pos = byte_pos + 4'd1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            local_net   = 8'h00;
            byte_pos    = POS_SRC_MAC;
            in_frame    = 1'b0;
            hdr_byte    = 8'h00;
            src_mac     = 8'h00;
            dst_mac     = 8'h00;
            frame_len   = 8'h00;
            hdr_bytes   = 4'd0;
            field_bytes = '{default: 8'h00};
            expected_hdrs.delete();
        end else begin
            // results leave after their last byte has been decoded, so compare first
            if (i_out_valid && !i_out_stall) begin
                if (expected_hdrs.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected",
                                              i_out_word));
                end else begin
                    want = expected_hdrs.pop_front();
                    cmp_field("src_kind",       16'(i_out_word.src_kind),
                              16'(want.src_kind));
                    cmp_field("src_net",        16'(i_out_word.src_net),
                              16'(want.src_net));
                    cmp_field("src_node",       16'(i_out_word.src_node),
                              16'(want.src_node));
                    cmp_field("dst_kind",       16'(i_out_word.dst_kind),
                              16'(want.dst_kind));
                    cmp_field("dst_net",        16'(i_out_word.dst_net),
                              16'(want.dst_net));
                    cmp_field("dst_node",       16'(i_out_word.dst_node),
                              16'(want.dst_node));
                    cmp_field("src_port",       i_out_word.src_port, want.src_port);
                    cmp_field("dst_port",       i_out_word.dst_port, want.dst_port);
                    cmp_field("bus_src_mac",    16'(i_out_word.bus_src_mac),
                              16'(want.bus_src_mac));
                    cmp_field("payload_len",    16'(i_out_word.payload_len),
                              16'(want.payload_len));
                    cmp_field("payload_offset", 16'(i_out_word.payload_offset),
                              16'(want.payload_offset));
                    cmp_field("status",         16'(i_out_word.status),
                              16'(want.status));
                    n_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                local_net = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_byte(i_in_word);
        end
        o_pending    <= expected_hdrs.size();
        o_checked    <= n_checked;
        o_mismatches <= n_mismatch;
    end

endmodule

// ===== sim/tb_net_header_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_net_header_parser_top
// feeds the header parser a short directed set of frames, then random frames
// (mostly well formed, some with bad header bytes, some cut short) under
// several local_net values, with idle and stall bursts on both channels;
// nhp_result_checker predicts and checks every header word
// ----------------------------------------------------------------------------
module tb_net_header_parser_top;
    import nhp_pkg::*;

    localparam int N_PHASES       = 6;
    localparam int PHASE_BYTES    = 280;   // minimum frame bytes sent per phase
    localparam int WATCHDOG_LIMIT = 500;   // far above any correct quiet spell
    localparam int SETTLE_CYCLES  = 4;     // lets the input and result registers empty
    localparam int END_CYCLES     = 8;

    // kinds of random frame
    typedef enum logic [1:0] {
        FR_GOOD,     // complete frame with a valid header byte
        FR_BAD_HDR,  // header byte fails the mask check
        FR_CUT       // stops early, the next start drops it
    } t_frame_kind;

    // every block input starts at a known value
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_word   in_word   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;

    logic       in_stall;
    logic       out_valid;
    t_out_word  out_word;
    logic       cfg_ready;

    int pending;
    int checked;
    int mismatches;

    // knobs for the idle and stall bursts, switched per phase
    bit idle_on  = 1'b0;
    bit stall_on = 1'b0;

    int n_bytes    = 0;
    int n_frames   = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    net_header_parser_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    nhp_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_mismatches (mismatches)
    );

    // receiver side: random stall bursts while stall_on is set
    initial begin
        forever begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any word moving on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one frame byte; may first idle for a burst, returns once accepted
    // valid stays high on return so back-to-back bytes need no extra edge
    task automatic put_byte(input logic [7:0] b, input logic start);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid            <= 1'b1;
        in_word.frame_byte  <= b;
        in_word.frame_start <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_bytes++;
    endtask

    // drop valid and wait until every expected word is out and the pipe is
    // empty; the first edge lets the checker count the last accepted byte
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local_net(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // one random frame of the given kind, with optional stray bytes around it
    task automatic send_frame(input t_frame_kind kind);
        logic [7:0] bytes [12];
        logic [7:0] h;
        logic [7:0] flen;
        int         nhdr;
        int         nsend;

        // stray byte: ignored while idle, or continues a frame that was cut
        if ($urandom_range(0, 15) == 0) put_byte(8'($urandom), 1'b0);

        if (kind == FR_BAD_HDR) begin
            h = 8'($urandom);
            while ((h & HDR_MASK) == HDR_MATCH) h = 8'($urandom);
        end else begin
            // free bits random: multi mode, bit 2 and both port flags
            h = (8'($urandom) & ~HDR_MASK) | HDR_MATCH;
        end
        nhdr = 3 + (h[4] ? 2 : 0) + ((h[5] | h[4]) ? 2 : 0) + int'(h[1]) + int'(h[0]);

        // length byte: mostly enough for the header, sometimes short or extreme
        case ($urandom_range(0, 9))
            0:       flen = 8'h00;
            1:       flen = 8'hff;
            2:       flen = 8'($urandom_range(0, nhdr - 1));
            default: flen = 8'(nhdr + $urandom_range(0, 40));
        endcase

        foreach (bytes[i]) bytes[i] = 8'($urandom);
        bytes[2] = flen;
        bytes[3] = h;

        case (kind)
            FR_GOOD:    nsend = 3 + nhdr;
            FR_BAD_HDR: nsend = 4;
            default:    nsend = $urandom_range(1, 2 + nhdr);
        endcase

        for (int i = 0; i < nsend; i++) put_byte(bytes[i], i == 0);
        n_frames++;

        // payload bytes after the header are ignored by the parser
        if (kind != FR_CUT)
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
    endtask

    initial begin
        int          phase_base;
        int          pick;
        t_frame_kind kind;

        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_local_net(8'h00);

        // --- directed frames ---
        // a byte with no start before any frame is ignored
        put_byte(8'hff, 1'b0);
        // bad header byte, then a payload byte that must be ignored
        put_byte(8'h00, 1'b1);
        put_byte(8'hff, 1'b0);
        put_byte(8'h10, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h55, 1'b0);
        // frame dropped by a new start in the middle
        put_byte(8'h12, 1'b1);
        put_byte(8'h34, 1'b0);
        // local addresses only, no port flags, length zero is short
        put_byte(8'hff, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);
        // both multi bits and both port flags: longest header, length 255
        put_byte(8'h00, 1'b1);
        put_byte(8'hff, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'hb3, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h3c, 1'b0);
        put_byte(8'hc3, 1'b0);
        put_byte(8'ha5, 1'b0);
        put_byte(8'h5a, 1'b0);
        n_frames += 4;

        // --- random phases, each under its own local_net ---
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                if (p == 1) write_local_net(8'hff);
                else        write_local_net(8'($urandom));
            end
            // in/out bursts mixed per phase; the last phase runs flat out
            idle_on  = (p != 2) && (p != N_PHASES - 1);
            stall_on = (p != 1) && (p != N_PHASES - 1);
            phase_base = n_bytes;
            while (n_bytes - phase_base < PHASE_BYTES) begin
                pick = $urandom_range(0, 9);
                if (pick < 8)       kind = FR_GOOD;
                else if (pick == 8) kind = FR_BAD_HDR;
                else                kind = FR_CUT;
                send_frame(kind);
            end
            // a complete frame so the parser is idle before the next write
            send_frame(FR_GOOD);
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("sent %0d frame bytes in %0d frames, checked %0d header words",
                 n_bytes, n_frames, checked);
        $display("local_net written %0d times, incl. 0x00 and 0xff", n_settings);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/nhp_pkg.sv
hw/rtl/nhp_parse.sv
hw/rtl/net_header_parser_top.sv
sim/nhp_result_checker.sv
sim/tb_net_header_parser_top.sv
